// File: rtl/core/hrhp_pkg.sv
// Shared types, constants and pattern tables for the HTTP response header parser.
package hrhp_pkg;

   localparam int DATA_W       = 8;
   localparam int PHASE_W      = 2;
   localparam int STATUS_W     = 10;
   localparam int COUNT_W      = 32;
   localparam int CONN_W       = 2;
   localparam int MATCH_W      = 4;
   localparam int DIGITS_W     = 2;
   localparam int LENGTH_BITS_DEFAULT = 32;

   localparam logic [DATA_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [DATA_W-1:0] CHAR_LF    = 8'h0A;
   localparam logic [DATA_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [DATA_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [DATA_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [DATA_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [DATA_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [DATA_W-1:0] CHAR_H     = 8'h68;
   localparam logic [DATA_W-1:0] CHAR_C     = 8'h63;
   localparam logic [DATA_W-1:0] CHAR_N     = 8'h6E;
   localparam logic [DATA_W-1:0] CASE_OFFSET = 8'h20;

   localparam logic [MATCH_W-1:0] VERSION_LEN = 4'd8;
   localparam logic [MATCH_W-1:0] CLEN_LEN    = 4'd15;
   localparam logic [MATCH_W-1:0] CONN_LEN    = 4'd11;
   localparam logic [MATCH_W-1:0] CLOSE_LEN   = 4'd5;
   // "con" is shared by both header names; the fourth letter picks the branch.
   localparam logic [MATCH_W-1:0] SPLIT_POS   = 4'd3;
   localparam logic [DIGITS_W-1:0] LAST_DIGIT = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK = 10'd200;

   typedef enum logic [PHASE_W-1:0] {
      PH_SEEK    = 2'd0,
      PH_STATUS  = 2'd1,
      PH_HEADERS = 2'd2,
      PH_BODY    = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      LN_START    = 3'd0,
      LN_CLEN     = 3'd1,
      LN_CONN     = 3'd2,
      LN_LEN_VAL  = 3'd3,
      LN_CONN_VAL = 3'd4,
      LN_SKIP     = 3'd5,
      LN_CR       = 3'd6
   } line_type;

   typedef enum logic [CONN_W-1:0] {
      CONN_NONE  = 2'd0,
      CONN_CLOSE = 2'd1,
      CONN_KEEP  = 2'd2
   } conn_type;

   function automatic logic [DATA_W-1:0] to_lower(input logic [DATA_W-1:0] b);
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
         return b + CASE_OFFSET;
      end
      return b;
   endfunction

   function automatic logic [DATA_W-1:0] version_char(input logic [MATCH_W-1:0] i);
      unique case (i)
         4'd0: return 8'h68;    // h
         4'd1: return 8'h74;    // t
         4'd2: return 8'h74;    // t
         4'd3: return 8'h70;    // p
         4'd4: return 8'h2F;    // /
         4'd5: return 8'h31;    // 1
         4'd6: return 8'h2E;    // .
         4'd7: return 8'h31;    // 1
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] clen_char(input logic [MATCH_W-1:0] i);
      unique case (i)
         4'd0:  return 8'h63;   // c
         4'd1:  return 8'h6F;   // o
         4'd2:  return 8'h6E;   // n
         4'd3:  return 8'h74;   // t
         4'd4:  return 8'h65;   // e
         4'd5:  return 8'h6E;   // n
         4'd6:  return 8'h74;   // t
         4'd7:  return 8'h2D;   // -
         4'd8:  return 8'h6C;   // l
         4'd9:  return 8'h65;   // e
         4'd10: return 8'h6E;   // n
         4'd11: return 8'h67;   // g
         4'd12: return 8'h74;   // t
         4'd13: return 8'h68;   // h
         4'd14: return 8'h3A;   // :
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] conn_char(input logic [MATCH_W-1:0] i);
      unique case (i)
         4'd0:  return 8'h63;   // c
         4'd1:  return 8'h6F;   // o
         4'd2:  return 8'h6E;   // n
         4'd3:  return 8'h6E;   // n
         4'd4:  return 8'h65;   // e
         4'd5:  return 8'h63;   // c
         4'd6:  return 8'h74;   // t
         4'd7:  return 8'h69;   // i
         4'd8:  return 8'h6F;   // o
         4'd9:  return 8'h6E;   // n
         4'd10: return 8'h3A;   // :
         default: return 8'h00;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] close_char(input logic [MATCH_W-1:0] i);
      unique case (i)
         4'd0: return 8'h63;    // c
         4'd1: return 8'h6C;    // l
         4'd2: return 8'h6F;    // o
         4'd3: return 8'h73;    // s
         4'd4: return 8'h65;    // e
         default: return 8'h00;
      endcase
   endfunction

endpackage

// File: rtl/core/hrhp_if.sv
// Valid/ready channel interfaces for the parser's byte input and result output.
interface hrhp_req_if
   import hrhp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface hrhp_rsp_if
   import hrhp_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [PHASE_W-1:0]  phase;
   logic [STATUS_W-1:0] status_code;
   logic [COUNT_W-1:0]  content_length;
   logic [CONN_W-1:0]   connection_mode;
   logic [COUNT_W-1:0]  body_count;
   logic                message_done;
   logic                response_ok;

   modport source (output valid, output phase, output status_code, output content_length,
                   output connection_mode, output body_count, output message_done,
                   output response_ok, input ready);
   modport sink   (input valid, input phase, input status_code, input content_length,
                   input connection_mode, input body_count, input message_done,
                   input response_ok, output ready);
endinterface

// File: rtl/core/http_response_header_parser.sv
// Top level of the byte-serial HTTP/1.1 response header parser.
//
// Channel   Direction  Carries                                   Handshake
// req_chan  in         data_byte, one response byte              valid/ready
// rsp_chan  out        phase, status, length, connection, count,  valid/ready
//                      done and ok flags, one per input byte
//
// Each accepted byte yields exactly one result transaction. The byte sits in the input
// register while the parse logic works on it, and the edge on which the parse stage
// advances loads the result register. The parse state updates at that same edge, so while
// the result is not stalled the sustained rate is one byte per cycle without bubbles.
// Reset is synchronous and active high; it clears the parse state and both valid flags.
// A stalled result holds the parse stage; the input register takes a new byte only if empty.
module http_response_header_parser
   import hrhp_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   hrhp_req_if.sink  req_chan,
   hrhp_rsp_if.source rsp_chan
);

   // The length accumulates as 10*x + d; four extra bits catch any overflow past the maximum.
   localparam int MUL_W = LENGTH_BITS + 4;
   // Wide enough to compare a length against the 32-bit output maximum.
   localparam int EXT_W = (LENGTH_BITS > COUNT_W) ? LENGTH_BITS : COUNT_W + 1;
   localparam logic [EXT_W-1:0] OUT_MAX = EXT_W'({COUNT_W{1'b1}});

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [DATA_W-1:0] in_byte_ff;

   // Parse state.
   phase_type               phase_ff, phase_in;
   logic [MATCH_W-1:0]      match_ff, match_in;
   line_type                line_ff, line_in;
   logic [DIGITS_W-1:0]     digits_ff, digits_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [LENGTH_BITS-1:0]  length_ff, length_in;
   conn_type                conn_ff, conn_in;
   logic [LENGTH_BITS-1:0]  body_ff, body_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PHASE_W-1:0]  rsp_phase_ff, rsp_phase_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]  rsp_length_ff, rsp_length_in;
   logic [CONN_W-1:0]   rsp_conn_ff, rsp_conn_in;
   logic [COUNT_W-1:0]  rsp_body_ff, rsp_body_in;
   logic                rsp_done_ff, rsp_done_in;
   logic                rsp_ok_ff, rsp_ok_in;

   logic              advance;
   logic              done;
   logic [DATA_W-1:0] b;
   logic [DATA_W-1:0] lc;
   logic              is_digit;
   logic [3:0]        digit;
   logic [MUL_W-1:0]  len_prod;
   logic              len_ovf;
   logic [STATUS_W-1:0] status_step;
   logic [LENGTH_BITS-1:0] body_inc;
   logic [EXT_W-1:0]  length_ext;
   logic [EXT_W-1:0]  body_ext;

   // The parse stage moves when it holds a byte and the result register can take the result.
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign b        = in_byte_ff;
   assign lc       = to_lower(in_byte_ff);
   assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign digit    = is_digit ? 4'(b - CHAR_ZERO) : 4'd0;

   // Decimal accumulation of the length and status code, and the saturating body count.
   assign len_prod = (MUL_W'(length_ff) << 3) + (MUL_W'(length_ff) << 1) + MUL_W'(digit);
   assign len_ovf  = |len_prod[MUL_W-1:LENGTH_BITS];
   assign status_step = (status_ff << 3) + (status_ff << 1) + STATUS_W'(digit);
   assign body_inc = (body_ff != '1) ? body_ff + LENGTH_BITS'(1) : body_ff;

   // Next parse state.
   always_comb begin
      phase_in  = phase_ff;
      match_in  = match_ff;
      line_in   = line_ff;
      digits_in = digits_ff;
      status_in = status_ff;
      length_in = length_ff;
      conn_in   = conn_ff;
      body_in   = body_ff;
      done      = 1'b0;

      unique case (phase_ff)
         PH_SEEK: begin
            if (match_ff < VERSION_LEN && lc == version_char(match_ff)) begin
               match_in = match_ff + MATCH_W'(1);
               if (match_ff == VERSION_LEN - MATCH_W'(1)) begin
                  phase_in  = PH_STATUS;
                  match_in  = '0;
                  line_in   = LN_START;
                  digits_in = '0;
                  status_in = '0;
               end
            end else begin
               // A mismatch may itself start a new match.
               match_in = (lc == CHAR_H) ? MATCH_W'(1) : '0;
            end
         end

         PH_STATUS: begin
            // In this phase the line register only tells whether the code is finished.
            if (line_ff != LN_START) begin
               if (b == CHAR_LF) begin
                  phase_in = PH_HEADERS;
                  line_in  = LN_START;
                  match_in = '0;
               end
            end else if (b == CHAR_LF) begin
               phase_in = PH_HEADERS;
               line_in  = LN_START;
               match_in = '0;
            end else if (b == CHAR_CR) begin
               line_in = LN_CLEN;
            end else if (b == CHAR_SPACE && digits_ff == '0) begin
               // Leading space before the code.
            end else begin
               status_in = status_step;
               digits_in = digits_ff + DIGITS_W'(1);
               if (digits_ff == LAST_DIGIT - DIGITS_W'(1)) begin
                  line_in = LN_CLEN;
               end
            end
         end

         PH_HEADERS: begin
            unique case (line_ff)
               LN_START: begin
                  if (b == CHAR_CR) begin
                     line_in = LN_CR;
                  end else if (b == CHAR_LF) begin
                     line_in = LN_START;
                  end else if (lc == CHAR_C) begin
                     line_in  = LN_CLEN;
                     match_in = MATCH_W'(1);
                  end else begin
                     line_in = LN_SKIP;
                  end
               end
               LN_CLEN: begin
                  if (match_ff < CLEN_LEN && lc == clen_char(match_ff)) begin
                     match_in = match_ff + MATCH_W'(1);
                     if (match_ff == CLEN_LEN - MATCH_W'(1)) begin
                        line_in   = LN_LEN_VAL;
                        match_in  = '0;
                        length_in = '0;
                     end
                  end else if (match_ff == SPLIT_POS && lc == CHAR_N) begin
                     line_in  = LN_CONN;
                     match_in = SPLIT_POS + MATCH_W'(1);
                  end else begin
                     line_in  = (b == CHAR_LF) ? LN_START : LN_SKIP;
                     match_in = '0;
                  end
               end
               LN_CONN: begin
                  if (match_ff < CONN_LEN && lc == conn_char(match_ff)) begin
                     match_in = match_ff + MATCH_W'(1);
                     if (match_ff == CONN_LEN - MATCH_W'(1)) begin
                        line_in  = LN_CONN_VAL;
                        match_in = '0;
                     end
                  end else begin
                     line_in  = (b == CHAR_LF) ? LN_START : LN_SKIP;
                     match_in = '0;
                  end
               end
               LN_LEN_VAL: begin
                  if (b == CHAR_SPACE && match_ff == '0) begin
                     // Leading space before the value.
                  end else if (is_digit) begin
                     length_in = len_ovf ? '1 : len_prod[LENGTH_BITS-1:0];
                     match_in  = MATCH_W'(1);
                  end else begin
                     line_in  = (b == CHAR_LF) ? LN_START : LN_SKIP;
                     match_in = '0;
                  end
               end
               LN_CONN_VAL: begin
                  if (b == CHAR_SPACE && match_ff == '0) begin
                     // Leading space before the value.
                  end else if (match_ff < CLOSE_LEN && lc == close_char(match_ff)) begin
                     match_in = match_ff + MATCH_W'(1);
                     if (match_ff == CLOSE_LEN - MATCH_W'(1)) begin
                        conn_in  = CONN_CLOSE;
                        line_in  = LN_SKIP;
                        match_in = '0;
                     end
                  end else begin
                     conn_in  = CONN_KEEP;
                     line_in  = (b == CHAR_LF) ? LN_START : LN_SKIP;
                     match_in = '0;
                  end
               end
               LN_CR: begin
                  if (b == CHAR_LF) begin
                     // Empty line: the headers are over. A zero length completes here.
                     phase_in = PH_BODY;
                     line_in  = LN_START;
                     match_in = '0;
                     body_in  = '0;
                     done     = (length_ff == '0);
                  end else begin
                     line_in = LN_SKIP;
                  end
               end
               default: begin
                  if (b == CHAR_LF) begin
                     line_in = LN_START;
                  end
                  match_in = '0;
               end
            endcase
         end

         PH_BODY: begin
            body_in = body_inc;
            done    = (body_inc == length_ff);
         end
      endcase
   end

   // Result fields, taken from the state after this byte and before any clearing.
   assign length_ext = EXT_W'(length_in);
   assign body_ext   = EXT_W'(body_in);

   always_comb begin
      rsp_phase_in  = done ? PH_BODY : phase_in;
      rsp_status_in = status_in;
      rsp_length_in = (length_ext > OUT_MAX) ? '1 : length_ext[COUNT_W-1:0];
      rsp_conn_in   = conn_in;
      rsp_body_in   = (body_ext > OUT_MAX) ? '1 : body_ext[COUNT_W-1:0];
      rsp_done_in   = done;
      rsp_ok_in     = done && (status_in == STATUS_OK);
   end

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SEEK;
         match_ff     <= '0;
         line_ff      <= LN_START;
         digits_ff    <= '0;
         status_ff    <= '0;
         length_ff    <= '0;
         conn_ff      <= CONN_NONE;
         body_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (done) begin
               // The completed response clears everything for the next one.
               phase_ff  <= PH_SEEK;
               match_ff  <= '0;
               line_ff   <= LN_START;
               digits_ff <= '0;
               status_ff <= '0;
               length_ff <= '0;
               conn_ff   <= CONN_NONE;
               body_ff   <= '0;
            end else begin
               phase_ff  <= phase_in;
               match_ff  <= match_in;
               line_ff   <= line_in;
               digits_ff <= digits_in;
               status_ff <= status_in;
               length_ff <= length_in;
               conn_ff   <= conn_in;
               body_ff   <= body_in;
            end
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
      end
      if (advance) begin
         rsp_phase_ff  <= rsp_phase_in;
         rsp_status_ff <= rsp_status_in;
         rsp_length_ff <= rsp_length_in;
         rsp_conn_ff   <= rsp_conn_in;
         rsp_body_ff   <= rsp_body_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_ok_ff     <= rsp_ok_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.phase           = rsp_phase_ff;
   assign rsp_chan.status_code     = rsp_status_ff;
   assign rsp_chan.content_length  = rsp_length_ff;
   assign rsp_chan.connection_mode = rsp_conn_ff;
   assign rsp_chan.body_count      = rsp_body_ff;
   assign rsp_chan.message_done    = rsp_done_ff;
   assign rsp_chan.response_ok     = rsp_ok_ff;

   // A completed response leaves the parser back at the start of a new one.
   a_clear_after_done: assert property (@(posedge clock) disable iff (reset)
      (advance && done) |=> (phase_ff == PH_SEEK && body_ff == '0 && length_ff == '0))
      else $error("parse state not cleared after a completed response");

   // The body count stays below the declared length while the body is being read.
   a_body_below_length: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (body_ff < length_ff))
      else $error("body count reached the length without completing");

   // A waiting result freezes the parse state.
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=>
         ($stable(phase_ff) && $stable(body_ff) && $stable(length_ff) && $stable(match_ff)))
      else $error("parse state moved while the result was stalled");

   // The ok flag only ever accompanies a completion in a body phase result.
   a_ok_with_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ok_ff) |-> (rsp_done_ff && rsp_phase_ff == PH_BODY))
      else $error("response_ok without message_done");

endmodule
